FILE: src/msp_pkg.sv
package msp_pkg;

    localparam logic [7:0] DELIM = 8'h1F;
    localparam logic [7:0] TERM  = 8'h1E;

    localparam logic [7:0] ASCII_MAX  = 8'h7F;
    localparam logic [7:0] CONT_MAX   = 8'hBF;
    localparam logic [7:0] LEAD2_MAX  = 8'hDF;
    localparam logic [7:0] LEAD3_MAX  = 8'hEF;
    localparam logic [7:0] CONT_MASK  = 8'hC0;
    localparam logic [7:0] CONT_MARK  = 8'h80;
    localparam logic [7:0] LOW6_MASK  = 8'h3F;
    localparam logic [7:0] LOW5_MASK  = 8'h1F;
    localparam logic [7:0] LOW4_MASK  = 8'h0F;
    localparam logic [7:0] LOW3_MASK  = 8'h07;

    localparam int MAX_RESULTS = 3;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);
    localparam int RES_NW      = $clog2(MAX_RESULTS + 1);

    typedef enum logic [1:0] {
        KIND_IND  = 2'd0,
        KIND_SUB  = 2'd1,
        KIND_DATA = 2'd2,
        KIND_END  = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        PH_OUTSIDE = 2'd0,
        PH_CODE    = 2'd1,
        PH_DATA    = 2'd2
    } t_phase;

    typedef struct packed {
        t_phase      phase;
        logic [1:0]  pos;
        logic [7:0]  first_ind;
        logic [31:0] code_point;
        logic        pending;
        logic        muted;
    } t_state;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] value;
        logic [7:0] second;
        logic [9:0] tag;
        logic       last;
    } t_result;

    typedef t_result [MAX_RESULTS-1:0] t_result_set;

endpackage

FILE: src/msp_step.sv
module msp_step (
    input  msp_pkg::t_state                i_state,
    input  logic [7:0]                     i_data_byte,
    input  logic [9:0]                     i_field_tag,
    input  logic                           i_last_byte,
    input  logic                           i_utf8_mode,
    output msp_pkg::t_state                o_state,
    output msp_pkg::t_result_set           o_results,
    output logic [msp_pkg::RES_NW-1:0]     o_count
);

    logic is_delim;
    logic is_term;
    logic is_cont;
    logic data_flush;
    logic data_pass;
    logic data_decode;
    logic [31:0] decoded;

    assign is_delim = (i_data_byte == msp_pkg::DELIM);
    assign is_term  = (i_data_byte == msp_pkg::TERM);
    assign is_cont  = ((i_data_byte & msp_pkg::CONT_MASK) == msp_pkg::CONT_MARK);

    // Within a subfield: which actions this byte triggers.
    always_comb begin
        data_flush  = 1'b0;
        data_pass   = 1'b0;
        data_decode = 1'b0;
        if (is_delim || is_term) begin
            data_flush = 1'b1;
        end else if (!i_state.muted) begin
            if (!i_utf8_mode) begin
                data_flush = 1'b1;
                data_pass  = 1'b1;
            end else if (i_data_byte == 8'd0) begin
                data_flush = 1'b1;
            end else begin
                data_flush  = !is_cont;
                data_decode = 1'b1;
            end
        end
    end

    always_comb begin
        if (i_data_byte <= msp_pkg::ASCII_MAX) begin
            decoded = {24'd0, i_data_byte};
        end else if (i_data_byte <= msp_pkg::CONT_MAX) begin
            decoded = {i_state.code_point[25:0], i_data_byte[5:0] & msp_pkg::LOW6_MASK[5:0]};
        end else if (i_data_byte <= msp_pkg::LEAD2_MAX) begin
            decoded = {24'd0, i_data_byte & msp_pkg::LOW5_MASK};
        end else if (i_data_byte <= msp_pkg::LEAD3_MAX) begin
            decoded = {24'd0, i_data_byte & msp_pkg::LOW4_MASK};
        end else begin
            decoded = {24'd0, i_data_byte & msp_pkg::LOW3_MASK};
        end
    end

    always_comb begin
        msp_pkg::t_state s;
        logic [msp_pkg::RES_NW-1:0] n;
        s         = i_state;
        n         = '0;
        o_results = '0;

        if (i_state.pos == 2'd0) begin
            s.first_ind = i_data_byte;
            s.pos       = 2'd1;
        end else if (i_state.pos == 2'd1) begin
            o_results[n].kind   = msp_pkg::KIND_IND;
            o_results[n].value  = i_state.first_ind;
            o_results[n].second = i_data_byte;
            o_results[n].tag    = i_field_tag;
            n     = n + 1'b1;
            s.pos = 2'd2;
        end else begin
            unique case (i_state.phase)
                msp_pkg::PH_OUTSIDE: begin
                    if (is_delim) begin
                        s.phase = msp_pkg::PH_CODE;
                    end
                end
                msp_pkg::PH_CODE: begin
                    if (is_term) begin
                        s.phase = msp_pkg::PH_OUTSIDE;
                    end else begin
                        o_results[n].kind  = msp_pkg::KIND_SUB;
                        o_results[n].value = i_data_byte;
                        n            = n + 1'b1;
                        s.phase      = msp_pkg::PH_DATA;
                        s.code_point = '0;
                        s.pending    = 1'b0;
                        s.muted      = 1'b0;
                    end
                end
                msp_pkg::PH_DATA: begin
                    if (data_flush && s.pending) begin
                        s.pending = 1'b0;
                        if (s.code_point[31:8] == 24'd0) begin
                            o_results[n].kind  = msp_pkg::KIND_DATA;
                            o_results[n].value = s.code_point[7:0];
                            n = n + 1'b1;
                        end
                    end
                    if (is_delim || is_term) begin
                        s.phase = is_delim ? msp_pkg::PH_CODE : msp_pkg::PH_OUTSIDE;
                        s.muted = 1'b0;
                    end else if (data_pass) begin
                        o_results[n].kind  = msp_pkg::KIND_DATA;
                        o_results[n].value = i_data_byte;
                        n = n + 1'b1;
                    end else if (data_decode) begin
                        s.code_point = decoded;
                        s.pending    = 1'b1;
                    end else if (!i_state.muted && i_utf8_mode) begin
                        // zero byte: mute the rest of the subfield
                        s.muted = 1'b1;
                    end
                end
                default: begin
                    s.phase = msp_pkg::PH_OUTSIDE;
                end
            endcase
        end

        if (i_last_byte) begin
            if (s.pending && (s.code_point[31:8] == 24'd0)) begin
                o_results[n].kind  = msp_pkg::KIND_DATA;
                o_results[n].value = s.code_point[7:0];
                n = n + 1'b1;
            end
            o_results[n].kind = msp_pkg::KIND_END;
            o_results[n].last = 1'b1;
            n = n + 1'b1;
            s = '0;
        end

        o_state = s;
        o_count = n;
    end

endmodule

FILE: src/msp_queue.sv
module msp_queue (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic [msp_pkg::RES_NW-1:0]     i_push_n,
    input  msp_pkg::t_result_set           i_push_data,
    input  logic                           i_ready,
    output logic                           o_valid,
    output msp_pkg::t_result               o_data,
    output logic                           o_space_ok
);

    localparam int AW = msp_pkg::QUEUE_AW;
    localparam int CW = msp_pkg::QUEUE_CW;

    msp_pkg::t_result r_mem [msp_pkg::QUEUE_DEPTH];
    logic [AW-1:0] r_wptr;
    logic [AW-1:0] r_rptr;
    logic [CW-1:0] r_count;
    logic          pop;

    function automatic logic RES_LT(input int k, input logic [msp_pkg::RES_NW-1:0] n);
        RES_LT = (msp_pkg::RES_NW'(k) < n);
    endfunction

    assign o_valid = (r_count != '0);
    assign pop     = o_valid && i_ready;
    assign o_data  = r_mem[r_rptr];

    // room for a full set of results after this cycle's transfer
    assign o_space_ok = ((CW+1)'(r_count) + (CW+1)'(msp_pkg::MAX_RESULTS))
                        <= ((CW+1)'(msp_pkg::QUEUE_DEPTH) + (CW+1)'(pop));

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < msp_pkg::MAX_RESULTS; k++) begin
            if (RES_LT(k, i_push_n)) begin
                r_mem[r_wptr + AW'(k)] <= i_push_data[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= r_wptr + AW'(i_push_n);
            r_rptr  <= r_rptr + AW'(pop);
            r_count <= r_count + CW'(i_push_n) - CW'(pop);
        end
    end

endmodule

FILE: src/marc_subfield_parser_top.sv
// Subfield parser for one bibliographic data field, one byte per transfer.
// Bytes pass through an input register, byte-compare and UTF-8 decode
// logic, and a four-entry result queue that drives the output port.
// A byte is taken every cycle as long as the consumer takes one result per
// cycle; a byte that produces two or three results (indicators, flushed code
// point, data character, field end) queues them for the single output port,
// and input stalls while the queue lacks room for a full set of results.
// A byte's first result is offered once it has passed the input register
// and been written to the queue. The user must write the utf8_mode register
// via i_cfg_we/i_cfg_data only between fields; the block does not enforce it.
module marc_subfield_parser_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_data,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_data_byte,
    input  logic [9:0] i_field_tag,
    input  logic       i_last_byte,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [1:0] o_kind,
    output logic [7:0] o_value,
    output logic [7:0] o_second_indicator,
    output logic [9:0] o_tag_out,
    output logic       o_last
);

    logic       r_utf8_mode;
    logic       r_in_valid;
    logic [7:0] r_byte;
    logic [9:0] r_tag;
    logic       r_last;

    msp_pkg::t_state                r_state;
    msp_pkg::t_state                n_state;
    msp_pkg::t_result_set           step_res;
    logic [msp_pkg::RES_NW-1:0]     step_n;
    logic [msp_pkg::RES_NW-1:0]     push_n;
    logic                           space_ok;
    logic                           advance;
    msp_pkg::t_result               head;

    assign advance = r_in_valid && space_ok;
    assign o_ready = !r_in_valid || advance;
    assign push_n  = advance ? step_n : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_utf8_mode <= 1'b0;
            r_in_valid  <= 1'b0;
            r_state     <= '0;
        end else begin
            if (i_cfg_we) begin
                r_utf8_mode <= i_cfg_data;
            end
            if (o_ready) begin
                r_in_valid <= i_valid;
            end
            if (advance) begin
                r_state <= n_state;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_byte <= i_data_byte;
            r_tag  <= i_field_tag;
            r_last <= i_last_byte;
        end
    end

    msp_step u_step (
        .i_state     (r_state),
        .i_data_byte (r_byte),
        .i_field_tag (r_tag),
        .i_last_byte (r_last),
        .i_utf8_mode (r_utf8_mode),
        .o_state     (n_state),
        .o_results   (step_res),
        .o_count     (step_n)
    );

    msp_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push_n    (push_n),
        .i_push_data (step_res),
        .i_ready     (i_ready),
        .o_valid     (o_valid),
        .o_data      (head),
        .o_space_ok  (space_ok)
    );

    assign o_kind             = head.kind;
    assign o_value            = head.value;
    assign o_second_indicator = head.second;
    assign o_tag_out          = head.tag;
    assign o_last             = head.last;

    a_last_is_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last |-> o_kind == msp_pkg::KIND_END)
        else $error("last flag on a result that is not field end");

    a_field_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_last |=> r_state.pos == 2'd0 && r_state.phase == msp_pkg::PH_OUTSIDE)
        else $error("state not cleared after final byte");

    a_second_ind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_state.pos == 2'd1
        |-> step_n != '0 && step_res[0].kind == msp_pkg::KIND_IND)
        else $error("second byte did not report indicators");

endmodule

FILE: tb/marc_subfield_parser_top_tb.sv
module marc_subfield_parser_top_tb;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic       i_cfg_data;
    logic       i_valid;
    logic       o_ready;
    logic [7:0] i_data_byte;
    logic [9:0] i_field_tag;
    logic       i_last_byte;
    logic       o_valid;
    logic       i_ready;
    logic [1:0] o_kind;
    logic [7:0] o_value;
    logic [7:0] o_second_indicator;
    logic [9:0] o_tag_out;
    logic       o_last;

    marc_subfield_parser_top u_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_data         (i_cfg_data),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_data_byte        (i_data_byte),
        .i_field_tag        (i_field_tag),
        .i_last_byte        (i_last_byte),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_kind             (o_kind),
        .o_value            (o_value),
        .o_second_indicator (o_second_indicator),
        .o_tag_out          (o_tag_out),
        .o_last             (o_last)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // parser state as seen from outside
    logic            utf8_on;
    msp_pkg::t_phase sub_phase;
    logic [1:0]      byte_pos;
    logic [7:0]      ind1;
    logic [31:0]     cpoint;
    logic            cp_pending;
    logic            sub_muted;

    msp_pkg::t_result parsed_q[$];
    logic [7:0]       field_buf[$];
    int               err_count  = 0;
    int               sent_count = 0;
    bit               no_idle    = 1'b0;
    int               stall_left = 0;
    int               run_left   = 0;

    task automatic report_mismatch(input string msg);
        err_count++;
        $display("ERROR at %0t: %s", $time, msg);
    endtask

    task automatic clear_parse();
        sub_phase  = msp_pkg::PH_OUTSIDE;
        byte_pos   = 2'd0;
        ind1       = 8'd0;
        cpoint     = 32'd0;
        cp_pending = 1'b0;
        sub_muted  = 1'b0;
    endtask

    task automatic emit(input msp_pkg::t_kind k, input logic [7:0] v, input logic [7:0] s,
                        input logic [9:0] t, input logic l);
        msp_pkg::t_result r;
        r.kind   = k;
        r.value  = v;
        r.second = s;
        r.tag    = t;
        r.last   = l;
        parsed_q = {parsed_q, r};
    endtask

    task automatic buf_add(input logic [7:0] b);
        field_buf = {field_buf, b};
    endtask

    task automatic flush_code_point();
        if (cp_pending) begin
            cp_pending = 1'b0;
            if (cpoint <= 32'd255)
                emit(msp_pkg::KIND_DATA, cpoint[7:0], 8'd0, 10'd0, 1'b0);
        end
    endtask

    task automatic decode_utf8(input logic [7:0] b);
        if (b <= msp_pkg::ASCII_MAX)
            cpoint = {24'd0, b};
        else if (b <= msp_pkg::CONT_MAX)
            cpoint = {cpoint[25:0], b[5:0]};
        else if (b <= msp_pkg::LEAD2_MAX)
            cpoint = {24'd0, b & msp_pkg::LOW5_MASK};
        else if (b <= msp_pkg::LEAD3_MAX)
            cpoint = {24'd0, b & msp_pkg::LOW4_MASK};
        else
            cpoint = {24'd0, b & msp_pkg::LOW3_MASK};
        cp_pending = 1'b1;
    endtask

    task automatic parse_field_byte(input logic [7:0] b, input logic [9:0] tag,
                                    input logic lst);
        if (byte_pos == 2'd0) begin
            ind1     = b;
            byte_pos = 2'd1;
        end else if (byte_pos == 2'd1) begin
            emit(msp_pkg::KIND_IND, ind1, b, tag, 1'b0);
            byte_pos = 2'd2;
        end else begin
            case (sub_phase)
                msp_pkg::PH_OUTSIDE: begin
                    if (b == msp_pkg::DELIM)
                        sub_phase = msp_pkg::PH_CODE;
                end
                msp_pkg::PH_CODE: begin
                    if (b == msp_pkg::TERM) begin
                        sub_phase = msp_pkg::PH_OUTSIDE;
                    end else begin
                        emit(msp_pkg::KIND_SUB, b, 8'd0, 10'd0, 1'b0);
                        sub_phase  = msp_pkg::PH_DATA;
                        cpoint     = 32'd0;
                        cp_pending = 1'b0;
                        sub_muted  = 1'b0;
                    end
                end
                default: begin
                    if (b == msp_pkg::DELIM || b == msp_pkg::TERM) begin
                        flush_code_point();
                        sub_phase = (b == msp_pkg::DELIM) ? msp_pkg::PH_CODE
                                                          : msp_pkg::PH_OUTSIDE;
                        sub_muted = 1'b0;
                    end else if (sub_muted) begin
                        // muted until the subfield ends
                    end else if (!utf8_on) begin
                        flush_code_point();
                        emit(msp_pkg::KIND_DATA, b, 8'd0, 10'd0, 1'b0);
                    end else if (b == 8'd0) begin
                        flush_code_point();
                        sub_muted = 1'b1;
                    end else begin
                        if ((b & msp_pkg::CONT_MASK) != msp_pkg::CONT_MARK)
                            flush_code_point();
                        decode_utf8(b);
                    end
                end
            endcase
        end
        if (lst) begin
            flush_code_point();
            emit(msp_pkg::KIND_END, 8'd0, 8'd0, 10'd0, 1'b1);
            clear_parse();
        end
    endtask

    task automatic send_byte(input logic [7:0] b, input logic [9:0] tag, input logic lst);
        int gap;
        gap = 0;
        if (!no_idle && $urandom_range(0, 3) == 0)
            gap = $urandom_range(1, 12);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_data_byte <= b;
        i_field_tag <= tag;
        i_last_byte <= lst;
        do @(posedge i_clk); while (!o_ready);
        parse_field_byte(b, tag, lst);
        sent_count++;
    endtask

    task automatic send_field(input logic [9:0] tag, input logic close);
        foreach (field_buf[i])
            send_byte(field_buf[i], tag, close && (i == field_buf.size() - 1));
    endtask

    // drop valid, let every expected result out, then cover pipeline latency
    task automatic wait_idle();
        i_valid <= 1'b0;
        while (parsed_q.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic set_mode(input logic m);
        wait_idle();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= m;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        utf8_on = m;
    endtask

    task automatic push_utf8(input logic [31:0] cp);
        if (cp < 32'h80) begin
            buf_add(cp[7:0]);
        end else if (cp < 32'h800) begin
            buf_add({3'b110, cp[10:6]});
            buf_add({2'b10, cp[5:0]});
        end else if (cp < 32'h10000) begin
            buf_add({4'b1110, cp[15:12]});
            buf_add({2'b10, cp[11:6]});
            buf_add({2'b10, cp[5:0]});
        end else begin
            buf_add({5'b11110, cp[20:18]});
            buf_add({2'b10, cp[17:12]});
            buf_add({2'b10, cp[11:6]});
            buf_add({2'b10, cp[5:0]});
        end
    endtask

    // mostly well-formed fields with random content, some noise and odd lengths
    task automatic build_random_field();
        int shape;
        int nsub;
        int nchar;
        int r;
        field_buf.delete();
        shape = $urandom_range(0, 19);
        if (shape == 0) begin
            buf_add(8'($urandom_range(0, 255)));
        end else if (shape == 1) begin
            repeat (2) buf_add(8'($urandom_range(0, 255)));
        end else begin
            repeat (2) buf_add(8'($urandom_range(0, 255)));
            nsub = $urandom_range(1, 2);
            repeat (nsub) begin
                if ($urandom_range(0, 7) == 0)
                    buf_add(8'($urandom_range(0, 255)));
                buf_add(msp_pkg::DELIM);
                if ($urandom_range(0, 5) == 0)
                    buf_add(8'($urandom_range(0, 255)));
                else
                    buf_add(8'($urandom_range(8'h61, 8'h7A)));
                nchar = $urandom_range(0, 4);
                repeat (nchar) begin
                    r = $urandom_range(0, 15);
                    if (!utf8_on)
                        buf_add(8'($urandom_range(0, 255)));
                    else if (r < 9)
                        push_utf8($urandom_range(32'h80, 32'hFF));
                    else if (r < 12)
                        push_utf8($urandom_range(32'h20, 32'h7E));
                    else if (r == 12)
                        push_utf8($urandom_range(32'h100, 32'h10FFFF));
                    else if (r == 13)
                        buf_add(8'h00);
                    else if (r == 14)
                        buf_add(8'($urandom_range(0, 255)));
                    else
                        buf_add(8'($urandom_range(8'h80, 8'hBF)));
                end
            end
            if ($urandom_range(0, 3) != 0)
                buf_add(msp_pkg::TERM);
        end
    endtask

    task automatic test_indicators();
        set_mode(1'b0);
        field_buf = {8'h00, 8'hFF};
        send_field(10'd1023, 1'b1);
        // one-byte field: field end only
        field_buf = {msp_pkg::DELIM};
        send_field(10'd0, 1'b1);
    endtask

    task automatic test_passthrough();
        set_mode(1'b0);
        // zero and 0xFF data, delimiter as code, terminator in the code position cancels the code
        field_buf = {8'h20, 8'h31, msp_pkg::DELIM, 8'h61, 8'h00, 8'hFF, msp_pkg::DELIM,
                     msp_pkg::DELIM, msp_pkg::DELIM, msp_pkg::TERM, msp_pkg::DELIM};
        send_field(10'd245, 1'b1);
    endtask

    task automatic test_utf8();
        set_mode(1'b1);
        // e-acute kept, euro sign dropped, zero byte mutes the trailing 'B'
        field_buf = {8'h30, 8'h30, msp_pkg::DELIM, 8'h62, 8'hC3, 8'hA9, 8'hE2, 8'h82,
                     8'hAC, 8'h00, 8'h42, msp_pkg::TERM};
        send_field(10'd650, 1'b1);
    endtask

    task automatic test_mode_switch();
        set_mode(1'b1);
        field_buf = {8'h41, 8'h42, msp_pkg::DELIM, 8'h63, 8'hC3};
        send_field(10'd100, 1'b0);
        // pending code point must flush ahead of the pass-through byte
        set_mode(1'b0);
        field_buf = {8'h78, msp_pkg::DELIM};
        send_field(10'd100, 1'b1);
    endtask

    task automatic test_random(input logic m, input int n_items, input bit calm);
        int target;
        logic [9:0] tag;
        set_mode(m);
        no_idle = calm;
        target  = sent_count + n_items;
        while (sent_count < target) begin
            build_random_field();
            if ($urandom_range(0, 7) == 0)
                tag = 10'($urandom_range(0, 1023));
            else
                tag = 10'($urandom_range(0, 999));
            send_field(tag, 1'b1);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (no_idle) begin
            i_ready <= 1'b1;
        end else if (stall_left > 0) begin
            i_ready    <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (run_left > 0) begin
            i_ready  <= 1'b1;
            run_left <= run_left - 1;
        end else if ($urandom_range(0, 1) == 1) begin
            i_ready    <= 1'b0;
            stall_left <= $urandom_range(0, 11);
        end else begin
            i_ready  <= 1'b1;
            run_left <= $urandom_range(0, 29);
        end
    end

    task automatic check_field(input string name, input logic [9:0] got,
                               input logic [9:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
    endtask

    always @(posedge i_clk) begin : result_check
        msp_pkg::t_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (parsed_q.size() == 0) begin
                report_mismatch("result transfer with nothing expected");
            end else begin
                want = parsed_q.pop_front();
                check_field("kind", 10'(o_kind), 10'(want.kind));
                check_field("value", 10'(o_value), 10'(want.value));
                check_field("second_indicator", 10'(o_second_indicator),
                            10'(want.second));
                check_field("tag_out", o_tag_out, want.tag);
                check_field("last", 10'(o_last), 10'(want.last));
            end
        end
    end

    initial begin
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_data  = 1'b0;
        i_valid     = 1'b0;
        i_data_byte = 8'd0;
        i_field_tag = 10'd0;
        i_last_byte = 1'b0;
        utf8_on     = 1'b0;
        clear_parse();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_indicators();
        test_passthrough();
        test_utf8();
        test_mode_switch();
        test_random(1'b0, 25, 1'b0);
        test_random(1'b1, 40, 1'b0);
        test_random(1'b0, 15, 1'b0);
        test_random(1'b1, 30, 1'b1);

        wait_idle();
        if (parsed_q.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", parsed_q.size()));
        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        #2000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
